>>> design/pst_pkg.sv
// Shared types, constants and helpers for the knob soft-takeover block.
package pst_pkg;

    localparam int NUM_KNOBS    = 8;
    localparam int KNOB_BITS    = 3;
    localparam int VALUE_BITS   = 12;
    localparam int THRESH_BITS  = 12;
    localparam int OPCODE_BITS  = 2;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(164);

    typedef logic [KNOB_BITS-1:0]   t_knob;
    typedef logic [VALUE_BITS-1:0]  t_value;
    typedef logic [THRESH_BITS-1:0] t_thresh;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_MOVE        = 2'd0,
        OP_REARM_ONE   = 2'd1,
        OP_REARM_ALL   = 2'd2,
        OP_CAPTURE_ALL = 2'd3
    } t_opcode;

    // One command as it leaves the input register
    typedef struct packed {
        logic    strobe;
        t_opcode opcode;
        t_knob   knob;
        t_value  position;
        t_value  target;
    } t_cmd;

    // One result as it enters the output register
    typedef struct packed {
        logic   apply;
        t_value apply_value;
        t_knob  knob_out;
    } t_result;

    function automatic logic knob_in_range(input t_knob k);
        return (32'(k) < NUM_KNOBS);
    endfunction

endpackage

>>> design/pst_cmd_if.sv
// Command channel: opcode, knob index, position and target with valid/ready.
interface pst_cmd_if;
    import pst_pkg::*;

    logic   valid;
    logic   ready;
    logic [OPCODE_BITS-1:0] opcode;
    t_knob  knob_index;
    t_value position;
    t_value target;

    modport source (output valid, opcode, knob_index, position, target, input ready);
    modport sink   (input valid, opcode, knob_index, position, target, output ready);
endinterface

>>> design/pst_res_if.sv
// Result channel: apply flag, value and knob index with valid/ready.
interface pst_res_if;
    import pst_pkg::*;

    logic   valid;
    logic   ready;
    logic   apply;
    t_value apply_value;
    t_knob  knob_out;

    modport source (output valid, apply, apply_value, knob_out, input ready);
    modport sink   (input valid, apply, apply_value, knob_out, output ready);
endinterface

>>> design/pst_cfg_if.sv
// Configuration write channel: pickup threshold data with valid/ready.
interface pst_cfg_if;
    import pst_pkg::*;

    logic    valid;
    logic    ready;
    t_thresh data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> design/pot_soft_takeover.sv
// Top level of the knob soft-takeover (pickup) block.
//
// Usage:
//   i_cmd carries one command per transaction: move a knob (position and
//   the current target of its parameter), rearm one knob, rearm all knobs
//   or capture all knobs. o_res returns exactly one result per command:
//   apply, apply_value (the position when applied, else zero) and knob_out.
//   i_cfg writes the pickup threshold; write it only while the block is idle.
//   It is always ready.
// Pipeline and throughput:
//   A command is captured in the input register, decided against the knob
//   state when it moves on and lands in the output register. One command
//   per cycle is sustained while o_res is ready; the per-knob state is read
//   and updated in the same cycle as the decision, so back-to-back commands
//   on one knob see each other.
// Reset:
//   Every knob starts captured with no stored position; threshold is 164.
// Stall:
//   When o_res is held off, the result waits in the output register and the
//   input register still takes one more command before i_cmd.ready drops.
module pot_soft_takeover
    import pst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pst_cmd_if.sink   i_cmd,
    pst_res_if.source o_res,
    pst_cfg_if.sink   i_cfg
);

    logic    r_in_valid;
    t_cmd    r_in;
    logic    r_out_valid;
    t_result r_out;
    t_thresh r_thresh;

    logic    advance;
    t_cmd    bank_cmd;
    t_result bank_result;

    // Move the input register forward when the output slot is free or drains
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    // Hold the payload until it moves on
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in.strobe   <= 1'b1;
            r_in.opcode   <= t_opcode'(i_cmd.opcode);
            r_in.knob     <= i_cmd.knob_index;
            r_in.position <= i_cmd.position;
            r_in.target   <= i_cmd.target;
        end
    end

    always_comb begin
        bank_cmd        = r_in;
        bank_cmd.strobe = advance;
    end

    pst_knob_bank u_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (bank_cmd),
        .i_thresh (r_thresh),
        .o_result (bank_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= bank_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_thresh <= i_cfg.data;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.apply       = r_out.apply;
    assign o_res.apply_value = r_out.apply_value;
    assign o_res.knob_out    = r_out.knob_out;

endmodule

>>> design/pst_knob_bank.sv
// Per-knob state registers and the takeover decision for one command.
module pst_knob_bank
    import pst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_thresh i_thresh,
    output t_result o_result
);

    logic   r_captured [NUM_KNOBS];
    logic   r_has_pos  [NUM_KNOBS];
    t_value r_last_pos [NUM_KNOBS];

    logic   knob_ok;
    logic   is_move;
    logic   sel_captured;
    logic   sel_has_pos;
    t_value sel_last_pos;
    t_value diff;
    logic   near;
    logic   crossed;
    logic   take;

    assign knob_ok      = knob_in_range(i_cmd.knob);
    assign is_move      = (i_cmd.opcode == OP_MOVE);
    assign sel_captured = knob_ok ? r_captured[i_cmd.knob] : 1'b0;
    assign sel_has_pos  = knob_ok ? r_has_pos[i_cmd.knob]  : 1'b0;
    assign sel_last_pos = r_last_pos[i_cmd.knob];

    assign diff = (i_cmd.position >= i_cmd.target) ? (i_cmd.position - i_cmd.target)
                                                   : (i_cmd.target - i_cmd.position);
    assign near = (diff <= i_thresh);

    // Movement from the last position reached or crossed the target
    assign crossed = sel_has_pos &&
                     (((sel_last_pos <= i_cmd.target) && (i_cmd.position >= i_cmd.target)) ||
                      ((sel_last_pos >= i_cmd.target) && (i_cmd.position <= i_cmd.target)));

    assign take = sel_captured || near || crossed;

    always_comb begin
        o_result.apply       = is_move && knob_ok && take;
        o_result.apply_value = o_result.apply ? i_cmd.position : '0;
        o_result.knob_out    = ((i_cmd.opcode == OP_REARM_ALL) ||
                                (i_cmd.opcode == OP_CAPTURE_ALL)) ? '0 : i_cmd.knob;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KNOBS; k++) begin
                r_captured[k] <= 1'b1;
                r_has_pos[k]  <= 1'b0;
            end
        end else if (i_cmd.strobe) begin
            case (i_cmd.opcode)
                OP_MOVE: begin
                    if (knob_ok) begin
                        if (take) begin
                            r_captured[i_cmd.knob] <= 1'b1;
                        end
                        r_has_pos[i_cmd.knob] <= 1'b1;
                    end
                end
                OP_REARM_ONE: begin
                    if (knob_ok) begin
                        r_captured[i_cmd.knob] <= 1'b0;
                    end
                end
                OP_REARM_ALL: begin
                    for (int k = 0; k < NUM_KNOBS; k++) begin
                        r_captured[k] <= 1'b0;
                    end
                end
                OP_CAPTURE_ALL: begin
                    for (int k = 0; k < NUM_KNOBS; k++) begin
                        r_captured[k] <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Positions are only read once the has-position mark is set
    always_ff @(posedge i_clk) begin
        if (i_cmd.strobe && is_move && knob_ok) begin
            r_last_pos[i_cmd.knob] <= i_cmd.position;
        end
    end

endmodule

>>> design/pst_checker.sv
// Port-level checks for the soft-takeover block and their bind.
module pst_checker
    import pst_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input logic   i_out_apply,
    input t_value i_out_apply_value
);

    // Results drop out of view right after reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A fresh result follows a command transaction through the input and output registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without a command two cycles before");

    // A result that is not applied carries zero
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_apply) |-> (i_out_apply_value == '0))
        else $error("nonzero value on an unapplied result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_apply_value)))
        else $error("stalled result changed");

endmodule

bind pot_soft_takeover pst_checker u_pst_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_cmd.valid),
    .i_in_ready        (i_cmd.ready),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_out_apply       (o_res.apply),
    .i_out_apply_value (o_res.apply_value)
);

>>> sim/pot_soft_takeover_tb.sv
// Self-checking testbench for the knob soft-takeover block: driver, monitor and predictor.
`timescale 1ns / 1ps

module pot_soft_takeover_tb;
    import pst_pkg::*;

    localparam int CYCLE_LIMIT = 200000;  // generous bound on the whole run
    localparam int LONG_STALL  = 300;     // receiver hold-off while commands keep coming
    localparam int PRINT_LIMIT = 100;     // keep the log short when the block is badly off

    // One command as the stimulus builds it
    typedef struct {
        t_opcode op;
        t_knob   knob;
        t_value  pos;
        t_value  tgt;
    } t_knob_cmd;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pst_cmd_if cmd_ch ();
    pst_res_if res_ch ();
    pst_cfg_if cfg_ch ();

    pot_soft_takeover dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Commands waiting for the driver, and results the predictor has promised
    t_knob_cmd knob_cmds_pending[$];
    t_result   results_expected[$];

    // Predicted knob state and threshold
    logic    knob_locked   [NUM_KNOBS];
    logic    knob_seen     [NUM_KNOBS];
    t_value  knob_prev_pos [NUM_KNOBS];
    t_thresh pickup_dist;

    // Stimulus bookkeeping: where each knob's walk stands and what it aims at
    int     walk_pos  [NUM_KNOBS];
    t_value knob_goal [NUM_KNOBS];

    // Handshake flags sampled at the rising edge, read by the drivers at the falling edge
    bit cmd_fire;
    bit res_fire;
    bit cmd_busy;
    int cmd_gap;
    int res_wait;
    bit no_gaps;
    bit stall_phase;
    int stall_count;

    int mismatches;
    int cycle_count;
    int n_applied, n_held, n_by_crossing, n_rearm_one, n_rearm_all, n_capture_all;
    int n_results;

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Work out the result of one accepted command and advance the predicted state.
    function automatic t_result takeover_predict(input t_opcode op, input t_knob k,
                                                 input t_value pos, input t_value tgt);
        t_result r;
        t_value  prev;
        t_value  gap_to_tgt;
        logic    near;
        logic    crossed;
        r          = '0;
        r.knob_out = k;
        case (op)
            OP_MOVE: begin
                prev       = knob_prev_pos[k];
                gap_to_tgt = (pos >= tgt) ? t_value'(pos - tgt) : t_value'(tgt - pos);
                near       = (gap_to_tgt <= pickup_dist);
                // Reaching or passing the target in either direction counts,
                // but only once the knob has a stored position.
                crossed = knob_seen[k] && ((prev <= tgt && pos >= tgt) ||
                                           (prev >= tgt && pos <= tgt));
                if (knob_locked[k] || near || crossed) begin
                    if (!knob_locked[k] && !near)
                        n_by_crossing++;
                    knob_locked[k] = 1'b1;
                    r.apply        = 1'b1;
                    r.apply_value  = pos;
                    n_applied++;
                end else begin
                    n_held++;
                end
                // Store the position whether or not the move went through
                knob_seen[k]     = 1'b1;
                knob_prev_pos[k] = pos;
            end
            OP_REARM_ONE: begin
                knob_locked[k] = 1'b0;
                n_rearm_one++;
            end
            default: begin
                for (int i = 0; i < NUM_KNOBS; i++)
                    knob_locked[i] = (op == OP_CAPTURE_ALL);
                r.knob_out = '0;
                if (op == OP_CAPTURE_ALL)
                    n_capture_all++;
                else
                    n_rearm_all++;
            end
        endcase
        return r;
    endfunction

    // Cycle counter: end the run if it goes past the cycle limit.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, results_expected.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Monitor: record command transactions into the predictor and check every
    // result transaction against the oldest expectation.
    always @(posedge clk) begin : res_monitor
        t_result want;
        if (!rst_n) begin
            cmd_fire = 1'b0;
            res_fire = 1'b0;
        end else begin
            cmd_fire = cmd_ch.valid && cmd_ch.ready;
            res_fire = res_ch.valid && res_ch.ready;
            if (cmd_fire)
                results_expected.push_back(takeover_predict(t_opcode'(cmd_ch.opcode),
                    cmd_ch.knob_index, cmd_ch.position, cmd_ch.target));
            if (res_fire) begin
                n_results++;
                if (results_expected.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected (knob %0d)",
                                              res_ch.knob_out));
                end else begin
                    want = results_expected.pop_front();
                    if (res_ch.apply !== want.apply)
                        report_mismatch($sformatf("apply %b, expected %b (result %0d)",
                                                  res_ch.apply, want.apply, n_results));
                    if (res_ch.apply_value !== want.apply_value)
                        report_mismatch($sformatf("apply_value %0d, expected %0d (result %0d)",
                                                  res_ch.apply_value, want.apply_value,
                                                  n_results));
                    if (res_ch.knob_out !== want.knob_out)
                        report_mismatch($sformatf("knob_out %0d, expected %0d (result %0d)",
                                                  res_ch.knob_out, want.knob_out, n_results));
                end
            end
        end
    end

    // Driver: take the next pending command after a random gap and hold it
    // until the block accepts it. Keep valid high across back-to-back commands.
    always @(negedge clk) begin : cmd_driver
        t_knob_cmd c;
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
            cmd_busy = 1'b0;
            cmd_gap  = 0;
        end else begin
            if (cmd_busy && cmd_fire)
                cmd_busy = 1'b0;
            if (!cmd_busy) begin
                if (cmd_gap > 0) begin
                    cmd_gap--;
                    cmd_ch.valid <= 1'b0;
                end else if (knob_cmds_pending.size() != 0) begin
                    c = knob_cmds_pending.pop_front();
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.opcode     <= c.op;
                    cmd_ch.knob_index <= c.knob;
                    cmd_ch.position   <= c.pos;
                    cmd_ch.target     <= c.tgt;
                    cmd_busy = 1'b1;
                    cmd_gap  = no_gaps ? 0 : $urandom_range(0, 4);
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off counter: runs only while a stall phase is on.
    always @(negedge clk) begin
        if (!stall_phase)
            stall_count <= 0;
        else if (stall_count < LONG_STALL)
            stall_count <= stall_count + 1;
    end

    // Receiver: drop ready for a random number of cycles before each result,
    // and hold it low for the whole long stall.
    always @(negedge clk) begin : res_receiver
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            res_wait = 0;
        end else if (stall_phase && stall_count < LONG_STALL) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_fire)
                res_wait = no_gaps ? 0 : $urandom_range(0, 4);
            if (res_wait > 0) begin
                res_wait--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic queue_cmd(input t_opcode op, input int k, input int pos, input int tgt);
        t_knob_cmd c;
        c.op   = op;
        c.knob = t_knob'(k);
        c.pos  = t_value'(pos);
        c.tgt  = t_value'(tgt);
        knob_cmds_pending.push_back(c);
    endtask

    // Move a knob a random step along its walk; now and then jump anywhere,
    // now and then pick a new goal for its parameter.
    task automatic queue_walk_move(input int k);
        int p;
        if ($urandom_range(0, 7) == 0)
            knob_goal[k] = t_value'($urandom_range(0, 4095));
        case ($urandom_range(0, 15))
            0:       p = 0;
            1:       p = 4095;
            2, 3:    p = $urandom_range(0, 4095);
            default: p = walk_pos[k] + $urandom_range(0, 600) - 300;
        endcase
        if (p < 0)
            p = 0;
        if (p > 4095)
            p = 4095;
        walk_pos[k] = p;
        queue_cmd(OP_MOVE, k, p, knob_goal[k]);
    endtask

    // Random traffic: mostly knob walks, rearms followed by moves on the same
    // knob so that pickup is exercised, and whole-bank operations as noise.
    task automatic queue_random(input int count);
        int queued;
        int roll;
        int k;
        int run;
        queued = 0;
        while (queued < count) begin
            roll = $urandom_range(0, 99);
            k    = $urandom_range(0, NUM_KNOBS - 1);
            if (roll < 55) begin
                queue_walk_move(k);
                queued++;
            end else if (roll < 80) begin
                queue_cmd(OP_REARM_ONE, k, $urandom_range(0, 4095), $urandom_range(0, 4095));
                run = $urandom_range(2, 6);
                repeat (run) queue_walk_move(k);
                queued += run + 1;
            end else if (roll < 90) begin
                queue_cmd(OP_REARM_ALL, k, $urandom_range(0, 4095), $urandom_range(0, 4095));
                queued++;
            end else begin
                queue_cmd(OP_CAPTURE_ALL, k, $urandom_range(0, 4095), $urandom_range(0, 4095));
                queued++;
            end
        end
    endtask

    // Wait until every command is accepted and every result has come back.
    task automatic drain();
        while (knob_cmds_pending.size() != 0 || cmd_busy || results_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the pickup threshold; only called while the block is idle.
    task automatic write_pickup_dist(input int v);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = t_thresh'(v);
        do @(posedge clk); while (!cfg_ch.ready);
        pickup_dist = t_thresh'(v);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    initial begin
        // Drive every input to a known value before the first edge
        cmd_ch.valid      = 1'b0;
        cmd_ch.opcode     = OP_MOVE;
        cmd_ch.knob_index = '0;
        cmd_ch.position   = '0;
        cmd_ch.target     = '0;
        res_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        no_gaps           = 1'b0;
        stall_phase       = 1'b0;

        // Predicted state after reset: all knobs captured, nothing stored
        pickup_dist = THRESH_RESET;
        for (int i = 0; i < NUM_KNOBS; i++) begin
            knob_locked[i]   = 1'b1;
            knob_seen[i]     = 1'b0;
            knob_prev_pos[i] = '0;
            walk_pos[i]      = $urandom_range(0, 4095);
            knob_goal[i]     = t_value'($urandom_range(0, 4095));
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with the reset threshold of 164
        queue_cmd(OP_MOVE,        0,    0, 4095);  // captured at reset: applies at any distance
        queue_cmd(OP_REARM_ONE,   0, 4095,    0);
        queue_cmd(OP_MOVE,        0, 4095,    0);  // sweep from 0 up: starts on the target
        queue_cmd(OP_REARM_ONE,   1, 1234, 3210);
        queue_cmd(OP_MOVE,        1, 2000, 2500);  // first move, far: held back
        queue_cmd(OP_MOVE,        1, 2100, 2500);  // approaching, not there yet
        queue_cmd(OP_MOVE,        1, 2336, 2500);  // exactly at the threshold distance
        queue_cmd(OP_REARM_ONE,   1,    0,    0);
        queue_cmd(OP_MOVE,        1, 2335, 2500);  // one past the threshold, no crossing
        queue_cmd(OP_MOVE,        1, 2500, 2500);  // lands on the target
        queue_cmd(OP_REARM_ALL,   7, 4095, 4095);
        queue_cmd(OP_MOVE,        2, 4095,    0);  // no stored position, far away
        queue_cmd(OP_MOVE,        2, 4095,    0);  // still away, stored position does not cross
        queue_cmd(OP_CAPTURE_ALL, 5, 4095, 4095);
        queue_cmd(OP_MOVE,        2, 4095,    0);  // captured again
        queue_cmd(OP_MOVE,        7, 4095, 4095);
        queue_cmd(OP_REARM_ONE,   7, 1365, 2730);
        queue_cmd(OP_MOVE,        7, 3000, 1000);  // above the target, no crossing
        queue_cmd(OP_MOVE,        7,  500, 1000);  // passes the target downward
        queue_cmd(OP_REARM_ALL,   0, 2730, 1365);
        queue_cmd(OP_MOVE,        3,  100,  100);  // first move, exactly on the target
        queue_cmd(OP_MOVE,        4,    0,    1);  // first move, off by one
        drain();

        // Zero threshold: a rearmed knob takes over only on an exact hit or a crossing
        write_pickup_dist(0);
        queue_random(500);
        drain();

        // Widest threshold, no idling on either side
        write_pickup_dist(4095);
        no_gaps = 1'b1;
        queue_random(300);
        drain();
        no_gaps = 1'b0;

        // Random threshold with a long receiver stall at the start: let the
        // block fill and drop ready while the driver keeps offering
        write_pickup_dist($urandom_range(1, 4094));
        stall_phase = 1'b1;
        queue_random(500);
        drain();
        stall_phase = 1'b0;

        // Back to the default threshold, alternating idling and full-rate stretches
        write_pickup_dist(164);
        for (int chunk = 0; chunk < 4; chunk++) begin
            no_gaps = chunk[0];
            queue_random(175);
            while (knob_cmds_pending.size() != 0)
                @(posedge clk);
        end
        drain();
        repeat (10) @(posedge clk);

        if (results_expected.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      results_expected.size()));

        $display("covered %0d moves (%0d applied, %0d of them by crossing, %0d held back)",
                 n_applied + n_held, n_applied, n_by_crossing, n_held);
        $display("plus %0d single rearms, %0d bank rearms, %0d bank captures; %0d mismatches",
                 n_rearm_one, n_rearm_all, n_capture_all, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
design/pst_pkg.sv
design/pst_cmd_if.sv
design/pst_res_if.sv
design/pst_cfg_if.sv
design/pst_knob_bank.sv
design/pot_soft_takeover.sv
design/pst_checker.sv
sim/pot_soft_takeover_tb.sv
